@@ rtl/core/rms_pkg.sv @@
// Package for the running median core: default sizes and width helpers.
// No dependencies; every other file of the core imports it.
package rms_pkg;

  localparam int unsigned DEPTH_DEF        = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned COUNT_OUT_W      = 7;

endpackage

@@ rtl/core/rms_if.sv @@
// Stream channels of the running median core: sample request in, median request out.
// Depends on rms_pkg for the default sample width.
interface rms_in_if
  import rms_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface rms_out_if
  import rms_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SAMPLE_WIDTH:0] median_doubled;
  logic [COUNT_OUT_W-1:0]       count;
  logic                         overflow;

  modport source (output valid, output median_doubled, output count, output overflow,
                  input ready);
  modport sink   (input valid, input median_doubled, input count, input overflow,
                  output ready);
endinterface

@@ rtl/core/rms_cell.sv @@
// One slot of the sorted row: compares the new sample and shifts up from its neighbour.
// Depends on rms_pkg.
module rms_cell
  import rms_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned CNT_W        = $clog2(DEPTH_DEF + 1),
  parameter int unsigned INDEX        = 0
) (
  input  logic                           clk,
  input  logic                           ins_en,
  input  logic signed [SAMPLE_WIDTH-1:0] ins_val,
  input  logic [CNT_W-1:0]               cnt,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_val,
  input  logic                           prev_gt,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic                           gt
);

  logic signed [SAMPLE_WIDTH-1:0] val_r;
  logic signed [SAMPLE_WIDTH-1:0] val_nxt;
  logic                           occupied;
  logic                           at_end;

  assign occupied = CNT_W'(INDEX) < cnt;
  assign at_end   = CNT_W'(INDEX) == cnt;
  // gt is monotone along the occupied part of the row because that part is sorted
  assign gt       = occupied && (val_r > ins_val);

  always_comb begin
    priority if (prev_gt) begin
      val_nxt = prev_val;
    end else if (gt || at_end) begin
      val_nxt = ins_val;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en && (occupied || at_end)) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

@@ rtl/core/rms_median.sv @@
// Picks the one or two middle entries of the row and forms the doubled median.
// Depends on rms_pkg.
module rms_median
  import rms_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned CNT_W        = $clog2(DEPTH_DEF + 1),
  parameter int unsigned IDX_W        = $clog2(DEPTH_DEF)
) (
  input  logic signed [SAMPLE_WIDTH-1:0] vals [DEPTH],
  input  logic [CNT_W-1:0]               cnt,
  output logic signed [SAMPLE_WIDTH:0]   median_doubled
);

  logic [IDX_W-1:0]        half;
  logic [IDX_W-1:0]        half_m1;
  logic [SAMPLE_WIDTH-1:0] hi;
  logic [SAMPLE_WIDTH-1:0] lo;
  logic signed [SAMPLE_WIDTH-1:0] lo_sel;

  assign half    = IDX_W'(cnt >> 1);
  assign half_m1 = half - IDX_W'(1);

  // one-hot AND-OR selection across the row
  always_comb begin
    hi = '0;
    lo = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (IDX_W'(i) == half) begin
        hi = hi | vals[i];
      end
      if (IDX_W'(i) == half_m1) begin
        lo = lo | vals[i];
      end
    end
  end

  assign lo_sel = cnt[0] ? $signed(hi) : $signed(lo);
  assign median_doubled = (SAMPLE_WIDTH+1)'($signed(hi)) + (SAMPLE_WIDTH+1)'(lo_sel);

endmodule

@@ rtl/core/running_median_sorted_insert_core.sv @@
// Running median by sorted insertion into a row of compare-and-shift cells.
// Pipeline: an accepted request is inserted into the row and held as pending, then its
// median is selected into the output register. Throughput: 1 request per cycle unless
// the output stalls; the median is read from the row while the next sample goes in.
// Reset: synchronous active-low rst_n clears the held count and the pipeline valids;
// the sample row itself is not cleared and needs no clearing pass.
module running_median_sorted_insert_core
  import rms_pkg::*;
#(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rms_in_if.sink     in_ch,
  rms_out_if.source  out_ch
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic signed [SAMPLE_WIDTH-1:0] vals [DEPTH];
  logic                           gts  [DEPTH];

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_r;
  logic [CNT_W-1:0] pend_cnt_r;
  logic             pend_ovf_r;
  logic             out_valid_r;
  logic signed [SAMPLE_WIDTH:0] out_med_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_ovf_r;

  logic             full;
  logic             in_acc;
  logic             load_ok;
  logic [CNT_W-1:0] cnt_after;
  logic signed [SAMPLE_WIDTH:0] med;

  assign full      = cnt_r == CNT_W'(DEPTH);
  assign load_ok   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !pend_r || load_ok;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign cnt_after = full ? cnt_r : cnt_r + CNT_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = in_ch.last_sample ? '0 : cnt_after;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_row
    if (g == 0) begin : g_head
      rms_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CNT_W(CNT_W), .INDEX(g)) u_cell (
        .clk      (clk),
        .ins_en   (in_acc && !full),
        .ins_val  (in_ch.sample),
        .cnt      (cnt_r),
        .prev_val (in_ch.sample),
        .prev_gt  (1'b0),
        .val      (vals[g]),
        .gt       (gts[g])
      );
    end else begin : g_body
      rms_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CNT_W(CNT_W), .INDEX(g)) u_cell (
        .clk      (clk),
        .ins_en   (in_acc && !full),
        .ins_val  (in_ch.sample),
        .cnt      (cnt_r),
        .prev_val (vals[g-1]),
        .prev_gt  (gts[g-1]),
        .val      (vals[g]),
        .gt       (gts[g])
      );
    end
  end

  rms_median #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DEPTH        (DEPTH),
    .CNT_W        (CNT_W),
    .IDX_W        (IDX_W)
  ) u_median (
    .vals           (vals),
    .cnt            (pend_cnt_r),
    .median_doubled (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        pend_r <= 1'b1;
      end else if (load_ok) begin
        pend_r <= 1'b0;
      end
      if (load_ok) begin
        out_valid_r <= pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_cnt_r <= cnt_after;
      pend_ovf_r <= full;
    end
    if (load_ok && pend_r) begin
      out_med_r <= med;
      out_cnt_r <= pend_cnt_r;
      out_ovf_r <= pend_ovf_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.median_doubled = out_med_r;
  assign out_ch.count          = COUNT_OUT_W'(out_cnt_r);
  assign out_ch.overflow       = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("held count beyond depth");

  a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (pend_cnt_r != '0))
    else $error("pending result with empty store");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && pend_ovf_r) |-> (pend_cnt_r == CNT_W'(DEPTH)))
    else $error("overflow flagged below depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.last_sample && !full) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("held count did not advance on insert");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("request taken while result stalled");

endmodule
